FILE: hw/rtl/mlp_pkg.sv
// shared types, constants and the sigmoid table builder for the mlp inference block
// no dependencies
package mlp_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = VALUE_BITS - 5;
  localparam int ACC_BITS   = 40;
  localparam int SIG_DEPTH  = 1024;
  localparam int SIG_BITS   = $clog2(SIG_DEPTH);
  localparam int PROB_BITS  = 15;

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_BIAS    = 2'd1;
  localparam logic [1:0] OP_FEATURE = 2'd2;

  localparam logic [1:0] LAYER_OUT = 2'd2;

  localparam logic [1:0] CFG_INPUT   = 2'd0;
  localparam logic [1:0] CFG_HIDDEN1 = 2'd1;
  localparam logic [1:0] CFG_HIDDEN2 = 2'd2;

  typedef struct packed {
    logic [1:0]                   operation;
    logic [1:0]                   layer;
    logic [3:0]                   neuron;
    logic [3:0]                   source;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_feature;
  } in_item_t;

  typedef struct packed {
    logic [PROB_BITS-1:0] probability;
    logic                 positive_class;
  } out_item_t;

  typedef enum logic [1:0] {
    MAC_NONE = 2'd0,
    MAC_BIAS = 2'd1,
    MAC_TERM = 2'd2
  } mac_op_t;

  typedef struct packed {
    mac_op_t    op;
    logic [1:0] layer;
    logic [3:0] row;
    logic [3:0] col;
    logic       wb;
    logic       sig;
  } dp_cmd_t;

  typedef struct packed {
    logic [PROB_BITS-1:0] prob;
  } dp_stat_t;

  typedef logic [PROB_BITS-1:0] sig_rom_t [SIG_DEPTH];

  // shift-subtract division, only used while building the table
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid at the left edge of bin i, q0.15, integer-only
  function automatic logic [PROB_BITS-1:0] sig_entry(int i);
    longint          num;
    longint          sum;
    longint unsigned mag;
    longint unsigned a;
    longint unsigned y;
    longint unsigned term;
    longint unsigned e;
    longint unsigned s;
    longint unsigned p;
    longint unsigned one;
    bit              neg;
    int              k;
    one  = 64'd1 << 31;
    num  = 64'(16 * i) - 64'(8 * SIG_DEPTH);
    neg  = num < 0;
    mag  = neg ? longint'(-num) : longint'(num);
    a    = (mag << 31) >> SIG_BITS;
    y    = a >> 4;
    term = one;
    sum  = longint'(one);
    for (k = 1; k <= 16; k++) begin
      term = udiv((term * y) >> 31, 64'(k));
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    e = (sum < 0) ? 64'd0 : longint'(sum);
    for (k = 0; k < 4; k++) e = (e * e) >> 31;
    if (neg) s = udiv(one * e, one + e);
    else s = udiv(one * one, one + e);
    p = (s + (64'd1 << 15)) >> 16;
    return (p > 64'd32767) ? 15'd32767 : p[PROB_BITS-1:0];
  endfunction

  function automatic sig_rom_t build_sig();
    sig_rom_t t;
    for (int i = 0; i < SIG_DEPTH; i++) t[i] = sig_entry(i);
    return t;
  endfunction

endpackage

FILE: hw/rtl/mlp_forward_inference.sv
// mlp_forward_inference: one shared multiply-accumulate, sequenced neuron by neuron.
// store writes and non-final features are taken whenever the block is idle.
// the final feature starts a pass through every layer on the single mac; out_valid rises
// once the pass has ended and the output register is free.
// no item is taken during a pass; a finished result waits in an output register.
// reset (synchronous, active low) clears biases to zero and restores widths 8/10/10.
module mlp_forward_inference (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mlp_pkg::out_item_t out_item
);

  logic              in_acc, start;
  mlp_pkg::dp_cmd_t  cmd;
  mlp_pkg::dp_stat_t stat;

  assign in_acc = in_valid && in_ready;
  assign start  = in_acc && in_item.operation == mlp_pkg::OP_FEATURE && in_item.last_feature;

  mlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  mlp_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_item (in_item),
    .cmd     (cmd),
    .stat    (stat)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("input taken during pass");

  a_result_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a pass");

  a_no_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cmd.op == mlp_pkg::MAC_NONE && !cmd.wb && !cmd.sig))
    else $error("datapath command while idle");

endmodule

FILE: hw/rtl/mlp_dp.sv
// datapath: weight, bias and activation stores, shared mac, rounding, sigmoid lookup
// depends on mlp_pkg
module mlp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  mlp_pkg::in_item_t   in_item,
  input  mlp_pkg::dp_cmd_t    cmd,
  output mlp_pkg::dp_stat_t   stat
);

  localparam int WDEPTH = 3 * mlp_pkg::MAX_WIDTH * mlp_pkg::MAX_WIDTH;
  localparam int BDEPTH = 3 * mlp_pkg::MAX_WIDTH;
  localparam int VB     = mlp_pkg::VALUE_BITS;
  localparam int AB     = mlp_pkg::ACC_BITS;
  localparam mlp_pkg::sig_rom_t SigRom = mlp_pkg::build_sig();

  logic signed [VB-1:0] wmem [WDEPTH];
  logic signed [VB-1:0] bmem [BDEPTH];
  logic signed [VB-1:0] amem [BDEPTH];
  logic [BDEPTH-1:0]    bvalid_r;

  logic signed [VB-1:0] w_q, a_q, b_q;
  logic                 bv_q;
  mlp_pkg::mac_op_t     op1_r, op2_r;
  logic signed [AB-1:0] term_r, acc_r;
  logic signed [VB-1:0] z_r;
  logic [mlp_pkg::PROB_BITS-1:0] prob_r;

  logic                 w_we, b_we;
  logic signed [AB-1:0] rnd;
  logic signed [VB-1:0] sat;
  logic signed [17:0]   sig_sum;
  logic [mlp_pkg::SIG_BITS-1:0] sig_idx;
  logic                 a_we;
  logic [5:0]           a_wa;
  logic signed [VB-1:0] a_wd;
  logic signed [VB-1:0] b_use;

  assign w_we = in_acc && in_item.operation == mlp_pkg::OP_WEIGHT && in_item.layer != 2'd3;
  assign b_we = in_acc && in_item.operation == mlp_pkg::OP_BIAS && in_item.layer != 2'd3;

  // round half up then floor, saturate to the value range
  always_comb begin
    rnd = acc_r + AB'(1 << (mlp_pkg::FRAC_BITS - 1));
    rnd = rnd >>> mlp_pkg::FRAC_BITS;
    if (rnd > AB'(32767)) sat = 16'sh7fff;
    else if (rnd < -AB'(32768)) sat = 16'sh8000;
    else sat = rnd[VB-1:0];
  end

  always_comb begin
    a_we = 1'b0;
    a_wa = {2'b00, in_item.source};
    a_wd = in_item.value;
    if (in_acc && in_item.operation == mlp_pkg::OP_FEATURE) begin
      a_we = 1'b1;
    end else if (cmd.wb && cmd.layer != mlp_pkg::LAYER_OUT) begin
      a_we = 1'b1;
      a_wa = {cmd.layer + 2'd1, cmd.row};
      a_wd = sat[VB-1] ? '0 : sat;
    end
  end

  always_comb begin
    sig_sum = 18'(z_r) + 18'sd16384;
    if (sig_sum < 0) sig_idx = '0;
    else if (sig_sum[17:15] != 3'd0) sig_idx = '1;
    else sig_idx = sig_sum[14:5];
  end

  assign b_use = bv_q ? b_q : '0;

  always_ff @(posedge clk) begin
    if (w_we) wmem[{in_item.layer, in_item.neuron, in_item.source}] <= in_item.value;
    w_q <= wmem[{cmd.layer, cmd.row, cmd.col}];
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[{in_item.layer, in_item.neuron}] <= in_item.value;
    b_q <= bmem[{cmd.layer, cmd.row}];
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[a_wa] <= a_wd;
    a_q <= amem[{cmd.layer, cmd.col}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= '0;
      bv_q     <= 1'b0;
      op1_r    <= mlp_pkg::MAC_NONE;
      op2_r    <= mlp_pkg::MAC_NONE;
    end else begin
      if (b_we) bvalid_r[{in_item.layer, in_item.neuron}] <= 1'b1;
      bv_q  <= bvalid_r[{cmd.layer, cmd.row}];
      op1_r <= cmd.op;
      op2_r <= op1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (op1_r == mlp_pkg::MAC_BIAS) term_r <= AB'(b_use) <<< mlp_pkg::FRAC_BITS;
    else term_r <= AB'(w_q * a_q);
    if (op2_r == mlp_pkg::MAC_BIAS) acc_r <= term_r;
    else if (op2_r == mlp_pkg::MAC_TERM) acc_r <= acc_r + term_r;
    if (cmd.wb && cmd.layer == mlp_pkg::LAYER_OUT) z_r <= sat;
    if (cmd.sig) prob_r <= SigRom[sig_idx];
  end

  assign stat.prob = prob_r;

endmodule

FILE: hw/rtl/mlp_ctrl.sv
// controller: width registers, layer/neuron/column sequencer, result register
// depends on mlp_pkg
module mlp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [4:0]         cfg_wdata,
  input  logic               start,
  output logic               in_ready,
  output mlp_pkg::dp_cmd_t   cmd,
  input  mlp_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output mlp_pkg::out_item_t out_item
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_BIAS  = 8'b0000_0010,
    S_MAC   = 8'b0000_0100,
    S_DRAIN = 8'b0000_1000,
    S_WB    = 8'b0001_0000,
    S_SIG   = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] w0_r, w1_r, w2_r;
  logic [1:0] layer_r, layer_nxt;
  logic [3:0] row_r, row_nxt, col_r, col_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic       out_valid_r, out_valid_nxt;
  mlp_pkg::out_item_t out_item_r, out_item_nxt;
  logic [4:0] n_in, n_out;

  function automatic logic [4:0] clamp_w(logic [4:0] w);
    if (w == 5'd0) return 5'd1;
    if (w > 5'(mlp_pkg::MAX_WIDTH)) return 5'(mlp_pkg::MAX_WIDTH);
    return w;
  endfunction

  always_comb begin
    unique case (layer_r)
      2'd0:    begin n_in = clamp_w(w0_r); n_out = clamp_w(w1_r); end
      2'd1:    begin n_in = clamp_w(w1_r); n_out = clamp_w(w2_r); end
      default: begin n_in = clamp_w(w2_r); n_out = 5'd1; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    layer_nxt     = layer_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    cmd           = '0;
    cmd.op        = mlp_pkg::MAC_NONE;
    cmd.layer     = layer_r;
    cmd.row       = row_r;
    cmd.col       = col_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_BIAS;
          layer_nxt = 2'd0;
          row_nxt   = '0;
        end
      end
      S_BIAS: begin
        cmd.op    = mlp_pkg::MAC_BIAS;
        col_nxt   = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.op = mlp_pkg::MAC_TERM;
        if ({1'b0, col_r} == n_in - 5'd1) begin
          state_nxt = S_DRAIN;
          drain_nxt = '0;
        end else begin
          col_nxt = col_r + 4'd1;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd2) state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if ({1'b0, row_r} == n_out - 5'd1) begin
          row_nxt = '0;
          if (layer_r == mlp_pkg::LAYER_OUT) begin
            state_nxt = S_SIG;
          end else begin
            layer_nxt = layer_r + 2'd1;
            state_nxt = S_BIAS;
          end
        end else begin
          row_nxt   = row_r + 4'd1;
          state_nxt = S_BIAS;
        end
      end
      S_SIG: begin
        cmd.sig   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.probability    = stat.prob;
          out_item_nxt.positive_class = stat.prob > 15'd16384;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      w0_r        <= 5'd8;
      w1_r        <= 5'd10;
      w2_r        <= 5'd10;
      layer_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      drain_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      layer_r     <= layer_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      drain_r     <= drain_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          mlp_pkg::CFG_INPUT:   w0_r <= cfg_wdata;
          mlp_pkg::CFG_HIDDEN1: w1_r <= cfg_wdata;
          mlp_pkg::CFG_HIDDEN2: w2_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
